@@ hdl/tdpt_pkg.sv @@
// tdpt_pkg: shared types and constants for the text display position tracker
// no dependencies; imported by the controller, the datapath and the top level

package tdpt_pkg;

    localparam int FIELD_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAB_STOP_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTROL_AS_CARET  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HORIZONTAL_SCROLL = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRUNCATE_MODE     = 3'd4;

    localparam logic [7:0]  RST_TAB_STOP_WIDTH   = 8'd8;
    localparam logic        RST_CONTROL_AS_CARET = 1'b1;
    localparam logic [11:0] RST_LINE_WIDTH       = 12'd79;

    // request kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    // byte codes
    localparam logic [7:0] CH_SPACE   = 8'o040;
    localparam logic [7:0] CH_DEL     = 8'o177;
    localparam logic [7:0] CH_HIGH    = 8'o200;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_CAPTURE,
        DP_CHECK,
        DP_DIV,
        DP_MOVE,
        DP_OVER,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic early_done;
        logic early_skip;
        logic is_tab;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/tdpt_datapath.sv @@
// tdpt_datapath: configuration registers, packed position state, serial
// tab remainder unit and the result register; uses tdpt_pkg

module tdpt_datapath #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdpt_pkg::t_dp_op                    i_op,
    output tdpt_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [tdpt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tdpt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_next_ends_line,
    input  logic                                i_last_char,
    input  logic signed [tdpt_pkg::FIELD_BITS-1:0] i_start_column,
    input  logic [tdpt_pkg::FIELD_BITS-1:0]     i_start_row,
    input  logic signed [tdpt_pkg::FIELD_BITS-1:0] i_goal_column,
    input  logic [tdpt_pkg::FIELD_BITS-1:0]     i_goal_row,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [tdpt_pkg::FIELD_BITS-1:0] o_column,
    output logic [tdpt_pkg::FIELD_BITS-1:0]     o_row,
    output logic signed [tdpt_pkg::FIELD_BITS-1:0] o_previous_column,
    output logic                                o_continued,
    output logic                                o_finished
);
    import tdpt_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int W  = 2 * POSITION_BITS;
    localparam int CW = POSITION_BITS + 13;
    localparam int FB = FIELD_BITS;

    // configuration
    logic [7:0]  r_tab_stop;
    logic        r_caret;
    logic [11:0] r_line_width;
    logic [11:0] r_hscroll;
    logic        r_truncate;

    // position state, row above column
    logic [W-1:0] r_cp, r_tgt, r_prev;
    logic         r_skip, r_done, r_acc, r_ge;
    logic [7:0]   r_char;
    logic         r_ends, r_last;

    // remainder unit
    logic [P-1:0] r_num;
    logic [7:0]   r_rem;
    logic         r_vneg;

    logic                 r_out_valid;
    logic signed [FB-1:0] r_o_column, r_o_prev;
    logic [FB-1:0]        r_o_row;
    logic                 r_o_cont, r_o_fin;

    logic [7:0]   tw;
    logic [11:0]  hs_adj;
    logic [P-1:0] cp_col, cp_hi, prev_col, prev_hi;
    logic         before_cur;
    logic [W-1:0] start_cp, goal_cp;
    logic [P-1:0] tab_v, tab_mag;
    logic [8:0]   div_t, div_rem_n;
    logic         is_print;
    logic [8:0]   tab_delta;
    logic [2:0]   ctrl_delta;
    logic [P-1:0] nl_hi;
    logic [W-1:0] nl_cp, move_cp, wrap_cp;
    logic signed [CW-1:0] col_x, w_x;
    logic         overrun;
    logic [P-1:0] cur_row, prev_row;
    logic         fin, cont;

    always_comb begin
        tw       = (r_tab_stop == 8'd0) ? 8'd1 : r_tab_stop;
        hs_adj   = (r_hscroll != 12'd0) ? r_hscroll - 12'd1 : 12'd0;
        cp_col   = r_cp[P-1:0];
        cp_hi    = r_cp[W-1:P];
        prev_col = r_prev[P-1:0];
        prev_hi  = r_prev[W-1:P];
        before_cur = $signed(r_cp) < $signed(r_tgt);

        start_cp = ({{(W-FB){1'b0}}, i_start_row} << P)
                 + {{(W-FB){i_start_column[FB-1]}}, i_start_column};
        goal_cp  = ({{(W-FB){1'b0}}, i_goal_row} << P)
                 + {{(W-FB){i_goal_column[FB-1]}}, i_goal_column};

        // tab stops are measured from the scrolled margin
        tab_v   = cp_col + {{(P-12){1'b0}}, hs_adj};
        tab_mag = tab_v[P-1] ? ({P{1'b0}} - tab_v) : tab_v;

        // one restoring remainder step per cycle
        div_t     = {r_rem, r_num[P-1]};
        div_rem_n = (div_t >= {1'b0, tw}) ? div_t - {1'b0, tw} : div_t;

        is_print   = (r_char >= CH_SPACE) && (r_char < CH_DEL);
        tab_delta  = r_vneg ? ({1'b0, tw} + {1'b0, r_rem}) : ({1'b0, tw} - {1'b0, r_rem});
        ctrl_delta = (r_caret && (r_char < CH_HIGH)) ? 3'd2 : 3'd4;
        // newline: column to -hs_adj (a negative column has already borrowed a row)
        nl_hi   = cp_hi + {{(P-1){1'b0}}, cp_col[P-1]} + {{(P-1){1'b0}}, 1'b1};
        nl_cp   = {nl_hi, {P{1'b0}}} - {{(W-12){1'b0}}, hs_adj};

        if (is_print) begin
            move_cp = r_cp + {{(W-1){1'b0}}, 1'b1};
        end else if (r_char == CH_TAB) begin
            move_cp = r_cp + {{(W-9){1'b0}}, tab_delta};
        end else if (r_char == CH_NEWLINE) begin
            move_cp = nl_cp;
        end else begin
            move_cp = r_cp + {{(W-3){1'b0}}, ctrl_delta};
        end

        col_x   = $signed({{(CW-P){cp_col[P-1]}}, cp_col});
        w_x     = $signed({{(CW-12){1'b0}}, r_line_width});
        overrun = (col_x >= w_x) && ((col_x > w_x) || !r_ends);
        wrap_cp = r_cp + ({{(W-1){1'b0}}, 1'b1} << P) - {{(W-12){1'b0}}, r_line_width};

        cur_row  = cp_hi + {{(P-1){1'b0}}, cp_col[P-1]};
        prev_row = prev_hi + {{(P-1){1'b0}}, prev_col[P-1]};
        fin      = r_acc || r_last || !before_cur;
        cont     = (cur_row != prev_row) && (r_char != CH_NEWLINE);

        o_status.early_done = r_done || r_ge;
        o_status.early_skip = r_skip && (r_char != CH_NEWLINE);
        o_status.is_tab     = (r_char == CH_TAB);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_stop   <= RST_TAB_STOP_WIDTH;
            r_caret      <= RST_CONTROL_AS_CARET;
            r_line_width <= RST_LINE_WIDTH;
            r_hscroll    <= 12'd0;
            r_truncate   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TAB_STOP_WIDTH:    r_tab_stop   <= i_cfg_data[7:0];
                CFG_CONTROL_AS_CARET:  r_caret      <= i_cfg_data[0];
                CFG_LINE_WIDTH:        r_line_width <= i_cfg_data;
                CFG_HORIZONTAL_SCROLL: r_hscroll    <= i_cfg_data;
                CFG_TRUNCATE_MODE:     r_truncate   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp        <= '0;
            r_tgt       <= '0;
            r_skip      <= 1'b0;
            r_done      <= 1'b0;
            r_acc       <= 1'b0;
            r_ge        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                DP_LOAD: begin
                    r_cp   <= start_cp;
                    r_tgt  <= goal_cp;
                    r_skip <= 1'b0;
                    r_acc  <= 1'b0;
                    r_ge   <= 1'b0;
                end
                DP_CAPTURE: begin
                    r_ge  <= !before_cur;
                    r_acc <= 1'b0;
                end
                DP_CHECK: begin
                    if (o_status.early_done) begin
                        r_acc <= 1'b1;
                    end else if (!o_status.early_skip) begin
                        r_skip <= 1'b0;
                    end
                end
                DP_MOVE: begin
                    r_cp <= move_cp;
                end
                DP_OVER: begin
                    if (overrun) begin
                        if (!before_cur) begin
                            r_acc <= 1'b1;
                        end else if ((r_hscroll == 12'd0) && !r_truncate) begin
                            r_cp <= wrap_cp;
                        end else if (r_char != CH_NEWLINE) begin
                            r_skip <= 1'b1;
                        end
                    end
                end
                DP_EMIT: begin
                    r_done <= fin;
                end
                default: ;
            endcase
        end
    end

    // item, remainder and result payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_prev <= start_cp;
                r_char <= i_char_code;
                r_ends <= i_next_ends_line;
                r_last <= 1'b0;
            end
            DP_CAPTURE: begin
                r_prev <= r_cp;
                r_char <= i_char_code;
                r_ends <= i_next_ends_line;
                r_last <= i_last_char;
                r_vneg <= tab_v[P-1];
                r_num  <= tab_mag;
                r_rem  <= 8'd0;
            end
            DP_DIV: begin
                r_num <= r_num << 1;
                r_rem <= div_rem_n[7:0];
            end
            DP_EMIT: begin
                r_o_column <= FB'($signed(cp_col));
                r_o_row    <= FB'(cur_row);
                r_o_prev   <= FB'($signed(prev_col));
                r_o_cont   <= cont;
                r_o_fin    <= fin;
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_column          = r_o_column;
    assign o_row             = r_o_row;
    assign o_previous_column = r_o_prev;
    assign o_continued       = r_o_cont;
    assign o_finished        = r_o_fin;

endmodule

@@ hdl/tdpt_controller.sv @@
// tdpt_controller: sequencer that steps the datapath through one request
// uses tdpt_pkg for the datapath command and status types

module tdpt_controller #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_operation,
    output logic                 o_in_stall,
    output tdpt_pkg::t_dp_op     o_op,
    input  tdpt_pkg::t_dp_status i_status
);
    import tdpt_pkg::*;

    localparam int CNT_W = $clog2(POSITION_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MOVE,
        S_OVER,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic               r_in_stall;
    logic [CNT_W-1:0]   r_div_cnt;
    logic               accept;

    assign accept     = i_in_valid && !r_in_stall;
    assign o_in_stall = r_in_stall;

    always_comb begin
        case (r_state)
            S_IDLE:  o_op = accept ? ((i_operation == OP_CHAR) ? DP_CAPTURE : DP_LOAD) : DP_NOP;
            S_CHECK: o_op = DP_CHECK;
            S_DIV:   o_op = DP_DIV;
            S_MOVE:  o_op = DP_MOVE;
            S_OVER:  o_op = DP_OVER;
            S_EMIT:  o_op = i_status.out_free ? DP_EMIT : DP_NOP;
            default: o_op = DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_stall <= 1'b1;
                        r_state    <= (i_operation == OP_CHAR) ? S_CHECK : S_EMIT;
                    end
                end
                S_CHECK: begin
                    r_div_cnt <= '0;
                    if (i_status.early_done || i_status.early_skip) begin
                        r_state <= S_EMIT;
                    end else if (i_status.is_tab) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_MOVE;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == CNT_W'(POSITION_BITS - 1)) begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: r_state <= S_OVER;
                S_OVER: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_in_stall <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/text_display_position_tracker.sv @@
// text_display_position_tracker: top level, controller plus datapath
// start request: load, then emit; character request: check, move, overrun check, emit,
// check then emit when already finished or skipping; tab: remainder steps before move
// one request in flight; the next is taken once the result sits in the output register
// synchronous active-low reset clears position, target and flags and loads the
// register defaults; a stalled result is held until taken

module text_display_position_tracker #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tdpt_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [tdpt_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_operation,
    input  logic [7:0]                             i_char_code,
    input  logic                                   i_next_ends_line,
    input  logic                                   i_last_char,
    input  logic signed [tdpt_pkg::FIELD_BITS-1:0] i_start_column,
    input  logic [tdpt_pkg::FIELD_BITS-1:0]        i_start_row,
    input  logic signed [tdpt_pkg::FIELD_BITS-1:0] i_goal_column,
    input  logic [tdpt_pkg::FIELD_BITS-1:0]        i_goal_row,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tdpt_pkg::FIELD_BITS-1:0] o_column,
    output logic [tdpt_pkg::FIELD_BITS-1:0]        o_row,
    output logic signed [tdpt_pkg::FIELD_BITS-1:0] o_previous_column,
    output logic                                   o_continued,
    output logic                                   o_finished
);
    import tdpt_pkg::*;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    tdpt_controller #(
        .POSITION_BITS(POSITION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .o_op        (dp_op),
        .i_status    (dp_status)
    );

    tdpt_datapath #(
        .POSITION_BITS(POSITION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (dp_op),
        .o_status          (dp_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_char_code       (i_char_code),
        .i_next_ends_line  (i_next_ends_line),
        .i_last_char       (i_last_char),
        .i_start_column    (i_start_column),
        .i_start_row       (i_start_row),
        .i_goal_column     (i_goal_column),
        .i_goal_row        (i_goal_row),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_column          (o_column),
        .o_row             (o_row),
        .o_previous_column (o_previous_column),
        .o_continued       (o_continued),
        .o_finished        (o_finished)
    );

endmodule

@@ hdl/tdpt_checker.sv @@
// tdpt_checker: port-level assertions for the position tracker
// bound to text_display_position_tracker; uses tdpt_pkg for port widths

module tdpt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [tdpt_pkg::FIELD_BITS-1:0] o_column,
    input logic [tdpt_pkg::FIELD_BITS-1:0]        o_row,
    input logic signed [tdpt_pkg::FIELD_BITS-1:0] o_previous_column,
    input logic                                   o_continued,
    input logic                                   o_finished
);
    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_column) && $stable(o_row)
            && $stable(o_previous_column) && $stable(o_continued) && $stable(o_finished))
        else $error("result changed while stalled");

    // one request at a time: intake closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // a result appears only for a request in flight
    a_result_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result with no request in flight");

    // reset leaves no result pending and the intake open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the handshake state");

endmodule

bind text_display_position_tracker tdpt_checker u_tdpt_checker (.*);
